// ===== hw/rtl/srfs_pkg.sv =====
package srfs_pkg;

  // Character codes used by the splitter.
  localparam logic [7:0] ChTab   = 8'd9;
  localparam logic [7:0] ChLf    = 8'd10;
  localparam logic [7:0] ChCr    = 8'd13;
  localparam logic [7:0] ChSpace = 8'd32;
  localparam logic [7:0] ChPlus  = 8'd43;
  localparam logic [7:0] ChMinus = 8'd45;
  localparam logic [7:0] ChZero  = 8'd48;
  localparam logic [7:0] ChNine  = 8'd57;

  // Field indexes with a special role.
  localparam logic [3:0] LastSplitField = 4'd10;
  localparam logic [3:0] RestField      = 4'd11;

  // Result queue geometry.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // One field result as it waits in the output queue.
  typedef struct packed {
    logic [3:0]  field_number;
    logic        is_numeric;
    logic [31:0] numeric_value;
    logic [11:0] start_offset;
    logic [12:0] field_length;
    logic        record_done;
  } srfs_result_t;

  // FLAG, POS, MAPQ, PNEXT and TLEN carry integers.
  function automatic logic field_is_numeric(input logic [3:0] f);
    return (f == 4'd1) || (f == 4'd3) || (f == 4'd4) || (f == 4'd7) || (f == 4'd8);
  endfunction

endpackage

// ===== hw/rtl/sam_record_field_splitter.sv =====
// SAM record field splitter.
// The slave stream carries one byte of an alignment record line per request,
// with tlast on the line's final byte. The master stream carries one request
// per closed field: tdata holds the field index, the parsed integer (zero
// for text fields), the start offset and the length; tuser flags the
// integer fields and tlast marks the final field of the line.
// Each input byte updates the line state in the cycle it is accepted and
// writes zero, one or two results into a four-entry output queue, so a
// result can appear on the master side in the cycle after its closing byte.
// Bytes are taken one per cycle while the queue has room for two results;
// results leave one per cycle while the receiver is ready, and input and
// output overlap.
// Reset empties the queue and returns the line state to the start of a line.
// When the receiver stalls, results wait in the queue and tready on the
// slave side drops once fewer than two entries are free.
module sam_record_field_splitter #(
  parameter int unsigned LINE_BYTES = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic        s_axis_tlast,   // line_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [3:0] field_number, [35:4] numeric_value, [47:36] start_offset,
  // [60:48] field_length, [63:61] zero
  output logic [63:0] m_axis_tdata,
  output logic        m_axis_tuser,   // is_numeric
  output logic        m_axis_tlast    // record_done
);
  import srfs_pkg::*;

  localparam int unsigned PosW = $clog2(LINE_BYTES + 1);
  localparam logic [PosW-1:0] LineMax = PosW'(LINE_BYTES);
  localparam logic [PosW-1:0] StartLim = PosW'(LINE_BYTES - 1);
  localparam logic [PosW:0]   StartMax = (PosW + 1)'(LINE_BYTES - 1);

  typedef enum logic [1:0] {
    NUM_LEAD,
    NUM_DIGITS,
    NUM_STOP
  } num_phase_e;

  // Line state.
  logic [3:0]      cur_field_q, cur_field_d;
  logic [PosW-1:0] byte_pos_q, byte_pos_d;
  logic [PosW-1:0] field_begin_q, field_begin_d;
  logic [PosW-1:0] pend_breaks_q, pend_breaks_d;
  logic [31:0]     acc_q, acc_d;
  logic            neg_q, neg_d;
  num_phase_e      phase_q, phase_d;

  // Output queue.
  srfs_result_t        queue_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] count_q;

  logic            in_fire, out_fire;
  logic [7:0]      c;
  logic            is_digit, is_space, is_break, tab_split, extra;
  logic            push0, push1;
  logic [3:0]      cur_last;
  logic [PosW-1:0] pos_next, begin_last, len_tab, len_raw, len_last;
  logic [PosW-1:0] start_tab, start_last;
  logic [31:0]     acc_f, val_tab, val_last;
  logic            neg_f;
  num_phase_e      phase_f;
  logic [PosW:0]   rest_start;
  srfs_result_t    res_tab, res_last, res_rest, res0, res1;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (count_q < QueueCntW'(QueueDepth - 1));

  assign c         = s_axis_tdata;
  assign is_digit  = (c >= ChZero) && (c <= ChNine);
  assign is_space  = ((c >= ChTab) && (c <= ChCr)) || (c == ChSpace);
  assign is_break  = (c == ChCr) || (c == ChLf);
  assign tab_split = (c == ChTab) && (cur_field_q <= LastSplitField);
  assign pos_next  = (byte_pos_q == LineMax) ? byte_pos_q : byte_pos_q + 1'b1;

  // atoi-style number parse for the current byte.
  always_comb begin
    acc_f   = acc_q;
    neg_f   = neg_q;
    phase_f = phase_q;
    if (!tab_split && field_is_numeric(cur_field_q)) begin
      unique case (phase_q)
        NUM_LEAD: begin
          if (is_space) begin
            phase_f = NUM_LEAD;
          end else if (c == ChPlus) begin
            phase_f = NUM_DIGITS;
          end else if (c == ChMinus) begin
            neg_f   = 1'b1;
            phase_f = NUM_DIGITS;
          end else if (is_digit) begin
            acc_f   = 32'(c - ChZero);
            phase_f = NUM_DIGITS;
          end else begin
            phase_f = NUM_STOP;
          end
        end
        NUM_DIGITS: begin
          if (is_digit) begin
            acc_f = (acc_q << 3) + (acc_q << 1) + 32'(c - ChZero);
          end else begin
            phase_f = NUM_STOP;
          end
        end
        default: phase_f = phase_q;
      endcase
    end
  end

  // Field boundaries and results for the current byte.
  always_comb begin
    val_tab  = neg_q ? (32'd0 - acc_q) : acc_q;
    len_tab  = (byte_pos_q > field_begin_q) ? byte_pos_q - field_begin_q : '0;

    pend_breaks_d = '0;
    if (!tab_split && is_break && (byte_pos_q != '0)) begin
      pend_breaks_d = (pend_breaks_q == LineMax) ? pend_breaks_q : pend_breaks_q + 1'b1;
    end

    cur_last   = tab_split ? cur_field_q + 4'd1 : cur_field_q;
    begin_last = tab_split ? pos_next : field_begin_q;
    len_raw    = (pos_next > begin_last) ? pos_next - begin_last : '0;
    len_last   = (len_raw > pend_breaks_d) ? len_raw - pend_breaks_d : '0;
    extra      = (cur_last == LastSplitField) && !tab_split;
    // After a tab the number state starts over, so a tab-closed line ends at zero.
    val_last   = tab_split ? 32'd0 : (neg_f ? (32'd0 - acc_f) : acc_f);
    rest_start = {1'b0, begin_last} + {1'b0, len_last};
    if (rest_start > StartMax) begin
      rest_start = StartMax;
    end

    // A field that begins past the end of the offset range reports the last offset.
    start_tab  = (field_begin_q > StartLim) ? StartLim : field_begin_q;
    start_last = (begin_last > StartLim) ? StartLim : begin_last;

    res_tab.field_number  = cur_field_q;
    res_tab.is_numeric    = field_is_numeric(cur_field_q);
    res_tab.numeric_value = res_tab.is_numeric ? val_tab : 32'd0;
    res_tab.start_offset  = 12'(start_tab);
    res_tab.field_length  = 13'(len_tab);
    res_tab.record_done   = 1'b0;

    res_last.field_number  = cur_last;
    res_last.is_numeric    = field_is_numeric(cur_last);
    res_last.numeric_value = res_last.is_numeric ? val_last : 32'd0;
    res_last.start_offset  = 12'(start_last);
    res_last.field_length  = 13'(len_last);
    res_last.record_done   = !extra;

    res_rest.field_number  = RestField;
    res_rest.is_numeric    = 1'b0;
    res_rest.numeric_value = 32'd0;
    res_rest.start_offset  = 12'(rest_start);
    res_rest.field_length  = 13'd0;
    res_rest.record_done   = 1'b1;

    res0  = tab_split ? res_tab : res_last;
    res1  = tab_split ? res_last : res_rest;
    push0 = in_fire && (tab_split || s_axis_tlast);
    push1 = in_fire && s_axis_tlast && (tab_split || extra);
  end

  // Next line state.
  always_comb begin
    cur_field_d   = cur_field_q;
    byte_pos_d    = byte_pos_q;
    field_begin_d = field_begin_q;
    acc_d         = acc_q;
    neg_d         = neg_q;
    phase_d       = phase_q;
    if (in_fire) begin
      byte_pos_d = pos_next;
      if (tab_split) begin
        cur_field_d   = cur_field_q + 4'd1;
        field_begin_d = pos_next;
        acc_d         = '0;
        neg_d         = 1'b0;
        phase_d       = NUM_LEAD;
      end else begin
        acc_d   = acc_f;
        neg_d   = neg_f;
        phase_d = phase_f;
      end
      if (s_axis_tlast) begin
        cur_field_d   = '0;
        byte_pos_d    = '0;
        field_begin_d = '0;
        acc_d         = '0;
        neg_d         = 1'b0;
        phase_d       = NUM_LEAD;
      end
    end
  end

  // Line state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_field_q   <= '0;
      byte_pos_q    <= '0;
      field_begin_q <= '0;
      pend_breaks_q <= '0;
      acc_q         <= '0;
      neg_q         <= 1'b0;
      phase_q       <= NUM_LEAD;
    end else begin
      cur_field_q   <= cur_field_d;
      byte_pos_q    <= byte_pos_d;
      field_begin_q <= field_begin_d;
      acc_q         <= acc_d;
      neg_q         <= neg_d;
      phase_q       <= phase_d;
      if (in_fire) begin
        pend_breaks_q <= s_axis_tlast ? '0 : pend_breaks_d;
      end
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push0) begin
      queue_q[wr_ptr_q] <= res0;
    end
    if (push1) begin
      queue_q[wr_ptr_q + 1'b1] <= res1;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QueuePtrW'(push0) + QueuePtrW'(push1);
      rd_ptr_q <= rd_ptr_q + QueuePtrW'(out_fire);
      count_q  <= count_q + QueueCntW'(push0) + QueueCntW'(push1) - QueueCntW'(out_fire);
    end
  end

  // Master side.
  assign m_axis_tvalid = (count_q != '0);
  assign m_axis_tdata  = {3'b000,
                          queue_q[rd_ptr_q].field_length,
                          queue_q[rd_ptr_q].start_offset,
                          queue_q[rd_ptr_q].numeric_value,
                          queue_q[rd_ptr_q].field_number};
  assign m_axis_tuser  = queue_q[rd_ptr_q].is_numeric;
  assign m_axis_tlast  = queue_q[rd_ptr_q].record_done;

endmodule

// ===== dv/sam_record_field_splitter_tb.sv =====
`timescale 1ns / 100ps

module sam_record_field_splitter_tb;
  import srfs_pkg::*;

  localparam int unsigned LineBytes = 4096;

  typedef enum logic [1:0] {
    NumLead,
    NumDigits,
    NumDone
  } num_phase_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;    // [7:0] text_byte
  logic        s_axis_tlast = 1'b0;  // line_end
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [3:0] field_number, [35:4] numeric_value, [47:36] start_offset,
  // [60:48] field_length, [63:61] zero
  logic [63:0] m_axis_tdata;
  logic        m_axis_tuser;         // is_numeric
  logic        m_axis_tlast;         // record_done

  // Line state of the predictor.
  logic [3:0]   cur_field;
  int unsigned  line_pos;
  int unsigned  fld_begin;
  int unsigned  brk_run;
  logic [31:0]  num_acc;
  logic         num_neg;
  num_phase_e   num_phase;

  srfs_result_t expected_fields[$];
  srfs_result_t want;
  logic [7:0]   line_buf[$];
  int           mismatches = 0;
  int unsigned  items_sent = 0;
  int unsigned  src_idle_pct = 25;
  int unsigned  sink_idle_pct = 85;

  sam_record_field_splitter #(
    .LINE_BYTES(LineBytes)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // The whole run must finish well inside this time.
  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

  // Receiver stalls at random with the current idle rate.
  initial begin
    forever begin
      @(negedge clk_i);
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  function automatic logic is_int_field(logic [3:0] f);
    return f inside {4'd1, 4'd3, 4'd4, 4'd7, 4'd8};
  endfunction

  function automatic int unsigned sat_inc(int unsigned v);
    return (v < LineBytes) ? v + 1 : LineBytes;
  endfunction

  function automatic void clear_number();
    num_acc   = '0;
    num_neg   = 1'b0;
    num_phase = NumLead;
  endfunction

  function automatic void reset_line();
    cur_field = '0;
    line_pos  = 0;
    fld_begin = 0;
    brk_run   = 0;
    clear_number();
  endfunction

  // Queue one expected field result, clamping offsets to the port widths.
  function automatic void push_field(logic [3:0] fnum, int unsigned start, int unsigned len,
                                     logic done);
    srfs_result_t r;
    r.field_number  = fnum;
    r.is_numeric    = is_int_field(fnum);
    r.numeric_value = r.is_numeric ? (num_neg ? -num_acc : num_acc) : '0;
    r.start_offset  = 12'((start > LineBytes - 1) ? LineBytes - 1 : start);
    r.field_length  = 13'((len > LineBytes) ? LineBytes : len);
    r.record_done   = done;
    expected_fields.push_back(r);
  endfunction

  // Advance the line state by one accepted byte and queue the fields it closes.
  function automatic void split_byte(logic [7:0] c, logic last);
    int unsigned p;
    int unsigned len;
    int unsigned closed;
    logic        is_digit;
    logic        is_space;
    logic        extra;
    p        = line_pos;
    closed   = 0;
    is_digit = (c >= ChZero) && (c <= ChNine);
    is_space = ((c >= ChTab) && (c <= ChCr)) || (c == ChSpace);
    if (c == ChTab && cur_field <= LastSplitField) begin
      brk_run = 0;
      push_field(cur_field, fld_begin, (p > fld_begin) ? p - fld_begin : 0, 1'b0);
      closed++;
      cur_field++;
      fld_begin = sat_inc(p);
      clear_number();
    end else begin
      // A CR/LF run only counts as trailing until some other byte follows.
      if ((c == ChCr || c == ChLf) && p > 0) begin
        brk_run = sat_inc(brk_run);
      end else begin
        brk_run = 0;
      end
      if (is_int_field(cur_field)) begin
        case (num_phase)
          NumLead: begin
            if (c == ChPlus) begin
              num_phase = NumDigits;
            end else if (c == ChMinus) begin
              num_neg   = 1'b1;
              num_phase = NumDigits;
            end else if (is_digit) begin
              num_acc   = 32'(c - ChZero);
              num_phase = NumDigits;
            end else if (!is_space) begin
              num_phase = NumDone;
            end
          end
          NumDigits: begin
            if (is_digit) begin
              num_acc = num_acc * 32'd10 + 32'(c - ChZero);
            end else begin
              num_phase = NumDone;
            end
          end
          default: begin
          end
        endcase
      end
    end
    line_pos = sat_inc(p);

    // End of line: close the open field, plus an empty rest field after field 10.
    if (last) begin
      len   = (line_pos > fld_begin) ? line_pos - fld_begin : 0;
      len   = (len > brk_run) ? len - brk_run : 0;
      extra = (cur_field == LastSplitField) && (closed == 0);
      push_field(cur_field, fld_begin, len, !extra);
      if (extra) begin
        push_field(RestField, fld_begin + len, 0, 1'b1);
      end
      reset_line();
    end
  endfunction

  function automatic void match_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
      mismatches++;
    end
  endfunction

  // Compare every accepted field result with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_fields.size() == 0) begin
        $error("field result with none expected: field_number %0d", m_axis_tdata[3:0]);
        mismatches++;
      end else begin
        want = expected_fields.pop_front();
        match_field("field_number", want.field_number, m_axis_tdata[3:0]);
        match_field("numeric_value", want.numeric_value, m_axis_tdata[35:4]);
        match_field("start_offset", want.start_offset, m_axis_tdata[47:36]);
        match_field("field_length", want.field_length, m_axis_tdata[60:48]);
        match_field("is_numeric", want.is_numeric, m_axis_tuser);
        match_field("record_done", want.record_done, m_axis_tlast);
      end
    end
  end

  // Send one byte; called and returning just after a falling edge.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    split_byte(b, last);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_line();
    if (line_buf.size() == 0) begin
      line_buf.push_back(8'($urandom_range(0, 255)));
    end
    foreach (line_buf[i]) send_byte(line_buf[i], i == line_buf.size() - 1);
    line_buf.delete();
  endtask

  function automatic void put_text(string s);
    foreach (s[i]) line_buf.push_back(s[i]);
  endfunction

  // Integer text: optional whitespace and sign, a digit run, sometimes junk after.
  function automatic void put_number();
    int unsigned n_digits;
    int unsigned pick;
    repeat ($urandom_range(3) == 0 ? $urandom_range(1, 2) : 0) begin
      pick = $urandom_range(0, 4);
      line_buf.push_back((pick == 4) ? ChSpace : 8'(10 + pick));
    end
    pick = $urandom_range(0, 5);
    if (pick == 0) line_buf.push_back(ChPlus);
    if (pick == 1) line_buf.push_back(ChMinus);
    n_digits = ($urandom_range(5) == 0) ? $urandom_range(0, 12) : $urandom_range(1, 5);
    repeat (n_digits) line_buf.push_back(8'(ChZero + $urandom_range(0, 9)));
    if ($urandom_range(5) == 0) begin
      line_buf.push_back(8'($urandom_range(0, 255)));
      line_buf.push_back(8'(ChZero + $urandom_range(0, 9)));
    end
  endfunction

  function automatic void put_word();
    logic any_byte;
    any_byte = ($urandom_range(7) == 0);
    repeat ($urandom_range(0, 8)) begin
      line_buf.push_back(any_byte ? 8'($urandom_range(0, 255)) : 8'($urandom_range(33, 126)));
    end
  endfunction

  task automatic wait_fields_drained();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (expected_fields.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // Edge cases: leading LF, tab ending field 9, eleven fields, CR/LF runs, zero byte.
  task automatic test_directed();
    put_text("\n");
    send_line();
    repeat (10) line_buf.push_back(ChTab);
    send_line();
    put_text("r\t-0012\tc\t 7x\t+\t\t\t4294967297\t\t\tq");
    send_line();
    line_buf.push_back(8'h00);
    line_buf.push_back(8'hFF);
    put_text("\015\na\015\n");
    send_line();
  endtask

  // Mostly SAM-like records with random content, some pure noise lines.
  task automatic test_random_lines(input int unsigned n_items);
    int unsigned goal;
    int unsigned n_fields;
    goal = items_sent + n_items;
    while (items_sent < goal) begin
      if ($urandom_range(99) < 12) begin
        repeat ($urandom_range(1, 16)) line_buf.push_back(8'($urandom_range(0, 255)));
      end else begin
        n_fields = ($urandom_range(99) < 40) ? $urandom_range(1, 14) : $urandom_range(10, 13);
        for (int f = 0; f < n_fields; f++) begin
          if (f > 0) line_buf.push_back(ChTab);
          if (is_int_field(4'(f))) begin
            put_number();
          end else begin
            put_word();
          end
        end
        if ($urandom_range(3) == 0) line_buf.push_back(ChTab);
        repeat ($urandom_range(0, 3)) line_buf.push_back($urandom_range(1) ? ChCr : ChLf);
      end
      send_line();
    end
  endtask

  // Lines past the offset range, so positions and lengths saturate.
  task automatic test_long_lines();
    repeat (LineBytes - 2) line_buf.push_back(8'h41);
    put_text("\t-12\txyz\t5\015\n");
    send_line();
    repeat (LineBytes + 100) line_buf.push_back(8'h43);
    put_text("\015\n");
    send_line();
  endtask

  initial begin
    reset_line();
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    src_idle_pct  = 25;
    sink_idle_pct = 85;
    test_directed();
    wait_fields_drained();
    test_random_lines(630);
    wait_fields_drained();

    src_idle_pct  = 85;
    sink_idle_pct = 25;
    test_random_lines(630);
    wait_fields_drained();

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_random_lines(640);
    test_long_lines();
    wait_fields_drained();

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
